// File: rtl/core/fss_pkg.sv
// Shared types, constants and the quarter-wave sine function for the
// Fourier series synthesis block. No dependencies.
`timescale 1ns / 1ps

package fss_pkg;

  localparam int DEF_POINTS        = 128;
  localparam int DEF_MAX_HARMONICS = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam int BIN_W   = 5;
  localparam int COEF_W  = 24;
  localparam int IDX_W   = 7;
  localparam int HC_W    = 5;
  localparam int VALUE_W = 32;
  localparam int TRIG_W  = 17;  // signed Q1.15 plus room for +1.0 on the DC bin

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [HC_W-1:0] HC_RESET = 5'd10;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // one command from the front end to the back end
  typedef struct packed {
    logic                     is_sample;
    logic [BIN_W-1:0]         bin;
    logic signed [COEF_W-1:0] re;
    logic signed [COEF_W-1:0] im;
    logic [IDX_W-1:0]         idx;
  } cmd_t;

  // sin(u*pi/2) for a Q30 u in [0, 1], rounded to Q1.15 and capped at 32767.
  // Evaluated at elaboration only, to build the lookup table.
  function automatic logic [14:0] quarter_sine(input longint unsigned u);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (u * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[14:0];
  endfunction

endpackage

// File: rtl/core/fss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fss_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/fss_front.sv
// Front end: takes input beats, drops loads to bins beyond the store and
// pushes the rest as commands into the queue. Uses fss_pkg.
`timescale 1ns / 1ps

module fss_front
  import fss_pkg::*;
#(
  parameter int MAX_HARMONICS = DEF_MAX_HARMONICS
) (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     op,
  input  logic [BIN_W-1:0]         bin_index,
  input  logic signed [COEF_W-1:0] bin_real,
  input  logic signed [COEF_W-1:0] bin_imag,
  input  logic [IDX_W-1:0]         sample_index,
  input  logic                     q_full,
  output logic                     q_push,
  output cmd_t                     q_cmd
);

  logic keep;

  // drop a load aimed past the last bin
  assign keep = (op == OP_SAMPLE) || (32'(bin_index) <= MAX_HARMONICS);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

  always_comb begin
    q_cmd.is_sample = (op == OP_SAMPLE);
    q_cmd.bin       = bin_index;
    q_cmd.re        = bin_real;
    q_cmd.im        = bin_imag;
    q_cmd.idx       = sample_index;
  end

endmodule

// File: rtl/core/fss_queue.sv
// Short command queue between front and back end.
// Uses fss_pkg for the command type and depth.
`timescale 1ns / 1ps

module fss_queue
  import fss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/fss_back.sv
// Back end: executes bin loads into the coefficient RAM and runs the
// per-harmonic multiply-accumulate for sample requests. Uses fss_pkg, fss_ram.
`timescale 1ns / 1ps

module fss_back
  import fss_pkg::*;
#(
  parameter int POINTS        = DEF_POINTS,
  parameter int MAX_HARMONICS = DEF_MAX_HARMONICS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [HC_W-1:0]           harmonic_count,
  input  logic                      q_not_empty,
  input  cmd_t                      q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] sample_value,
  output logic [IDX_W-1:0]          sample_number,
  output logic                      saturated
);

  localparam int DEPTH   = MAX_HARMONICS + 1;
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = $clog2(POINTS);
  localparam int QW      = PW - 2;
  localparam int QUARTER = POINTS / 4;
  localparam int SHIFT   = PW + 15;
  localparam int PROD_W  = COEF_W + TRIG_W + 1;
  localparam int ACC_W   = PROD_W + $clog2(DEPTH) + 1;
  localparam longint unsigned ROUND = 64'd1 << (SHIFT - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RUN    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;

  logic [2:0] state;

  // quarter-wave sine table, points 0..QUARTER of a quarter turn
  logic [14:0] qs_tab [QUARTER + 1];
  for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
    assign qs_tab[g] = quarter_sine(64'(g) << (30 - QW));
  end

  // coefficient store
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [2*COEF_W-1:0]      ram_wdata;
  logic [AW-1:0]            n;
  logic [2*COEF_W-1:0]      ram_rdata;
  logic [DEPTH-1:0]         bin_valid;
  logic                     vld_rd;

  fss_ram #(
    .WIDTH(2 * COEF_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(n),
    .rdata(ram_rdata)
  );

  logic             pop_load;
  logic             pop_sample;
  logic [IDX_W-1:0] idx;
  logic [PW-1:0]    idx_p;
  logic [PW-1:0]    k;
  logic [AW-1:0]    h_last;
  logic [AW-1:0]    h_clip;

  assign q_pop      = (state == S_IDLE) && q_not_empty;
  assign pop_load   = q_pop && !q_head.is_sample;
  assign pop_sample = q_pop && q_head.is_sample;
  assign ram_we     = pop_load;
  assign ram_waddr  = AW'(q_head.bin);
  assign ram_wdata  = {q_head.re, q_head.im};
  assign idx_p      = PW'(idx);
  assign h_clip     = (32'(harmonic_count) > MAX_HARMONICS) ? AW'(MAX_HARMONICS)
                                                            : AW'(harmonic_count);

  // pipeline: read -> trig lookup -> products -> accumulate
  logic                       p1_v;
  logic                       p1_dc;
  logic [PW-1:0]              p1_k;
  logic                       p2_v;
  logic signed [COEF_W-1:0]   p2_re;
  logic signed [COEF_W-1:0]   p2_im;
  logic signed [TRIG_W-1:0]   p2_c;
  logic signed [TRIG_W-1:0]   p2_s;
  logic                       p3_v;
  logic signed [PROD_W-1:0]   p3_sum;
  logic signed [PROD_W-1:0]   prod_sum;
  logic signed [ACC_W-1:0]    acc;

  logic [1:0]               quad;
  logic [QW-1:0]            jj;
  logic [QW:0]              jj_rev;
  logic signed [TRIG_W-1:0] ta;
  logic signed [TRIG_W-1:0] tb;
  logic signed [TRIG_W-1:0] cos_v;
  logic signed [TRIG_W-1:0] sin_v;

  assign quad   = p1_k[PW-1:PW-2];
  assign jj     = p1_k[QW-1:0];
  assign jj_rev = (QW + 1)'(QUARTER) - {1'b0, jj};
  assign ta     = $signed({2'b00, qs_tab[jj]});
  assign tb     = $signed({2'b00, qs_tab[jj_rev]});

  always_comb begin
    unique case (quad)
      2'd0: begin cos_v = tb;  sin_v = ta;  end
      2'd1: begin cos_v = -ta; sin_v = tb;  end
      2'd2: begin cos_v = -tb; sin_v = -ta; end
      2'd3: begin cos_v = ta;  sin_v = -tb; end
    endcase
  end

  assign prod_sum = p2_re * p2_c + p2_im * p2_s;

  // round, shift and clip the finished sum
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] q;
  logic signed [63:0]      q64;
  logic                    over;
  logic                    under;

  assign rnd   = acc + ACC_W'(ROUND);
  assign q     = rnd >>> SHIFT;
  assign q64   = 64'(q);
  assign over  = (q64 > 64'sd2147483647);
  assign under = (q64 < -64'sd2147483648);

  logic pipe_busy;
  logic out_free;

  assign pipe_busy = p1_v || p2_v || p3_v;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bin_valid <= '0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_v <= (state == S_RUN);
      p2_v <= p1_v;
      p3_v <= p2_v;
      if (pop_load) begin
        bin_valid[AW'(q_head.bin)] <= 1'b1;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_sample) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (n == h_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!pipe_busy) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register can take the result
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop_sample) begin
      idx    <= q_head.idx;
      h_last <= h_clip;
      n      <= '0;
      k      <= '0;
    end else if (state == S_RUN) begin
      n <= n + 1'b1;
      k <= k + idx_p;
    end

    vld_rd <= bin_valid[n];
    p1_k   <= k;
    p1_dc  <= (n == '0);

    p2_re <= vld_rd ? $signed(ram_rdata[2*COEF_W-1:COEF_W]) : '0;
    p2_im <= vld_rd ? $signed(ram_rdata[COEF_W-1:0]) : '0;
    // the DC bin carries a weight of exactly one
    p2_c  <= p1_dc ? TRIG_W'(32768) : cos_v;
    p2_s  <= p1_dc ? '0 : sin_v;

    p3_sum <= prod_sum;

    if (pop_sample) begin
      acc <= '0;
    end else if (p3_v) begin
      acc <= acc + ACC_W'(p3_sum);
    end

    if (state == S_FINISH && out_free) begin
      sample_number <= idx;
      saturated     <= over || under;
      if (over) begin
        sample_value <= 32'sh7fffffff;
      end else if (under) begin
        sample_value <= 32'sh80000000;
      end else begin
        sample_value <= q64[VALUE_W-1:0];
      end
    end
  end

endmodule

// File: rtl/core/fourier_series_synthesis.sv
// Top level of the Fourier series synthesis block: APB register, front end,
// command queue and back end. Uses fss_pkg, fss_front, fss_queue, fss_back.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  op, bin_index, bin_real, bin_imag,
//                                             sample_index
//   out       output     out_valid/out_stall  sample_value, sample_number,
//                                             saturated
//   apb       input      psel/penable/pready  paddr, pwdata, prdata
//
// A bin load is written into the coefficient RAM as it leaves the queue. A
// sample request runs one multiply-accumulate step per bin up to H, H being
// harmonic_count clipped to MAX_HARMONICS, through a four-stage read,
// lookup, multiply, accumulate pipeline, then a round-and-clip step.
// Reset clears the bin valid flags at once (all bins read as zero) and sets
// harmonic_count to 10. The two-entry queue keeps taking beats, until it is
// full, while the back end works or a result waits on out_stall.
`timescale 1ns / 1ps

module fourier_series_synthesis
  import fss_pkg::*;
#(
  parameter int POINTS        = DEF_POINTS,
  parameter int MAX_HARMONICS = DEF_MAX_HARMONICS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      op,
  input  logic [BIN_W-1:0]          bin_index,
  input  logic signed [COEF_W-1:0]  bin_real,
  input  logic signed [COEF_W-1:0]  bin_imag,
  input  logic [IDX_W-1:0]          sample_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] sample_value,
  output logic [IDX_W-1:0]          sample_number,
  output logic                      saturated,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam logic REG_HARMONIC_COUNT = 1'b0;

  logic [HC_W-1:0] harmonic_count;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_HARMONIC_COUNT) ? {27'd0, harmonic_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      harmonic_count <= HC_RESET;
    end else if (cfg_write && paddr[2] == REG_HARMONIC_COUNT) begin
      harmonic_count <= pwdata[HC_W-1:0];
    end
  end

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_head;

  fss_front #(
    .MAX_HARMONICS(MAX_HARMONICS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .bin_index   (bin_index),
    .bin_real    (bin_real),
    .bin_imag    (bin_imag),
    .sample_index(sample_index),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  fss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  fss_back #(
    .POINTS       (POINTS),
    .MAX_HARMONICS(MAX_HARMONICS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .harmonic_count(harmonic_count),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_value  (sample_value),
    .sample_number (sample_number),
    .saturated     (saturated)
  );

  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (sample_value == 32'sh7fffffff || sample_value == 32'sh80000000))
    else $error("saturated result is not a clip value");

  a_hc_reset: assert property (@(posedge clk)
    rst |=> harmonic_count == HC_RESET)
    else $error("harmonic_count not at reset value");

  a_out_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full && !q_pop |=> q_full)
    else $error("queue lost an entry while full");

endmodule
